// ===== src/tt_pkg.sv =====
// Shared types and constants for the text tokenizer.
package tt_pkg;

	localparam int MAX_RES = 4;
	localparam int RES_IDX_W = $clog2(MAX_RES);
	localparam int RES_CNT_W = $clog2(MAX_RES + 1);
	localparam int QDEPTH = 4;

	localparam logic [2:0] MODE_SKIP    = 3'd0;
	localparam logic [2:0] MODE_SLASH   = 3'd1;
	localparam logic [2:0] MODE_COMMENT = 3'd2;
	localparam logic [2:0] MODE_QUOTED  = 3'd3;
	localparam logic [2:0] MODE_WORD    = 3'd4;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_EOT  = 2'd2;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_APOS   = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] tok;
		logic       quoted;
	} res_t;

	// All results that one text byte causes, in order.
	typedef struct packed {
		logic [RES_CNT_W-1:0]         count;
		res_t [MAX_RES-1:0]           res;
	} batch_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== src/tt_front.sv =====
// Front end: accepts text bytes, tracks scan mode and builds result batches.
module tt_front import tt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	input  q_status_t  q_stat,
	output logic       in_ready,
	output logic       push,
	output batch_t     push_batch
);

	logic [2:0] mode_q;
	logic [2:0] mode_d;
	logic       is_zero, is_sp, is_single;
	res_t [2:0]           w_res;
	logic [1:0]           w_cnt;
	logic [2:0]           w_mode;
	logic                 accept;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		is_zero   = (in_byte == CH_NUL);
		is_sp     = (in_byte <= CH_SPACE) || in_byte[7];
		is_single = (in_byte == CH_LBRACE) || (in_byte == CH_RBRACE) ||
			(in_byte == CH_LPAREN) || (in_byte == CH_RPAREN) ||
			(in_byte == CH_APOS) || (in_byte == CH_COLON);
	end

	// Results of a byte that follows a word byte.
	always_comb begin
		w_res  = '0;
		w_cnt  = 2'd1;
		w_mode = MODE_SKIP;
		w_res[0].kind = KIND_END;
		if (is_zero) begin
			w_res[1].kind = KIND_EOT;
			w_cnt = 2'd2;
		end else if (is_single) begin
			w_res[1].kind = KIND_BYTE;
			w_res[1].tok  = in_byte;
			w_res[2].kind = KIND_END;
			w_cnt = 2'd3;
		end else if (!is_sp) begin
			w_res[0].kind = KIND_BYTE;
			w_res[0].tok  = in_byte;
			w_mode = MODE_WORD;
		end
	end

	always_comb begin
		mode_d     = mode_q;
		push_batch = '0;
		unique case (mode_q)
			MODE_SLASH: begin
				if (in_byte == CH_SLASH) begin
					mode_d = MODE_COMMENT;
				end else begin
					push_batch.res[0].kind = KIND_BYTE;
					push_batch.res[0].tok  = CH_SLASH;
					push_batch.res[3:1]    = w_res;
					push_batch.count       = RES_CNT_W'(w_cnt) + RES_CNT_W'(1);
					mode_d = w_mode;
				end
			end
			MODE_COMMENT: begin
				if (is_zero) begin
					push_batch.res[0].kind = KIND_EOT;
					push_batch.count = RES_CNT_W'(1);
					mode_d = MODE_SKIP;
				end else if (in_byte == CH_NL) begin
					mode_d = MODE_SKIP;
				end
			end
			MODE_QUOTED: begin
				push_batch.res[0].quoted = 1'b1;
				push_batch.count = RES_CNT_W'(1);
				if (in_byte == CH_QUOTE) begin
					push_batch.res[0].kind = KIND_END;
					mode_d = MODE_SKIP;
				end else if (is_zero) begin
					push_batch.res[0].kind = KIND_END;
					push_batch.res[1].kind = KIND_EOT;
					push_batch.count = RES_CNT_W'(2);
					mode_d = MODE_SKIP;
				end else begin
					push_batch.res[0].kind = KIND_BYTE;
					push_batch.res[0].tok  = in_byte;
				end
			end
			MODE_WORD: begin
				push_batch.res[2:0] = w_res;
				push_batch.count    = RES_CNT_W'(w_cnt);
				mode_d = w_mode;
			end
			default: begin
				if (is_zero) begin
					push_batch.res[0].kind = KIND_EOT;
					push_batch.count = RES_CNT_W'(1);
					mode_d = MODE_SKIP;
				end else if (is_sp) begin
					mode_d = MODE_SKIP;
				end else if (in_byte == CH_SLASH) begin
					mode_d = MODE_SLASH;
				end else if (in_byte == CH_QUOTE) begin
					mode_d = MODE_QUOTED;
				end else if (is_single) begin
					push_batch.res[0].kind = KIND_BYTE;
					push_batch.res[0].tok  = in_byte;
					push_batch.res[1].kind = KIND_END;
					push_batch.count = RES_CNT_W'(2);
					mode_d = MODE_SKIP;
				end else begin
					push_batch.res[0].kind = KIND_BYTE;
					push_batch.res[0].tok  = in_byte;
					push_batch.count = RES_CNT_W'(1);
					mode_d = MODE_WORD;
				end
			end
		endcase
	end

	// Drop bytes that cause no result.
	assign push = accept && (push_batch.count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SKIP;
		end else if (accept) begin
			mode_q <= mode_d;
		end
	end

endmodule

// ===== src/tt_queue.sv =====
// Short queue of result batches between front and back end.
module tt_queue import tt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  batch_t    push_batch,
	input  logic      pop,
	output batch_t    head,
	output q_status_t stat
);

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	batch_t             entry_q [QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign stat.full  = (cnt_q == CNT_W'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_batch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> !stat.full)
		else $error("queue pushed while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("queue popped while empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("queue count did not advance on push");

	a_no_empty_batch: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_batch.count != '0)
		else $error("empty batch queued");

endmodule

// ===== src/tt_back.sv =====
// Back end: issues the results of the head batch one request per cycle while out_ready is high.
module tt_back import tt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  batch_t     head,
	input  q_status_t  q_stat,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_tok,
	output logic [2:0] out_user,
	output logic       out_last
);

	logic [RES_IDX_W-1:0] idx_q;
	res_t                 cur;
	logic                 fire;

	assign out_valid = !q_stat.empty;
	assign cur       = head.res[idx_q];
	assign out_tok   = cur.tok;
	assign out_user  = {cur.quoted, cur.kind};
	assign out_last  = ({1'b0, idx_q} == head.count - RES_CNT_W'(1));
	assign fire      = out_valid && out_ready;
	assign pop       = fire && out_last;

	// Advance through the batch, restart on its last result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= out_last ? '0 : idx_q + RES_IDX_W'(1);
		end
	end

	a_idx_in_batch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, idx_q} < head.count)
		else $error("result index beyond batch");

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> idx_q == '0)
		else $error("result index not cleared with queue empty");

endmodule

// ===== src/text_tokenizer.sv =====
// Top level of the byte-serial text tokenizer.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata = text_byte
//  m_*      out  m_tvalid/m_tready  tdata = token_byte, tuser = kind, in_quotes,
//                                   tlast = last_of_run
//
// One text byte is taken per cycle while the batch queue has room.
// A byte can cause up to 4 results, which leave one at a time on m_*;
// the four-entry queue between front and back end absorbs the burst.
// Bytes that cause no result (whitespace, comment bytes) are not queued.
// Reset returns the scanner to skipping whitespace and empties the queue.
// Output stalls back up through the queue to s_tready only once it is full.
module text_tokenizer import tt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] token_byte
	output logic [2:0] m_tuser,   // [1:0] kind, [2] in_quotes
	output logic       m_tlast
);

	q_status_t q_stat;
	logic      push, pop;
	batch_t    push_batch, head;

	tt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_byte    (s_tdata),
		.q_stat     (q_stat),
		.in_ready   (s_tready),
		.push       (push),
		.push_batch (push_batch)
	);

	tt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_batch (push_batch),
		.pop        (pop),
		.head       (head),
		.stat       (q_stat)
	);

	tt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_tok   (m_tdata),
		.out_user  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

// ===== bench/testbench.sv =====
// Stream-level self-checking bench for the text tokenizer, with its own scanner model.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tt_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 36;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] tok;
		logic       quoted;
		logic       last;
	} tok_res_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [2:0] m_tuser;
	logic       m_tlast;

	logic [7:0] text_queue [$];
	tok_res_t   expected_tokens [$];
	tok_res_t   byte_results [$];
	logic [2:0] scan_state = MODE_SKIP;
	logic [7:0] directed_text [0:25];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int bytes_sent = 0;
	int results_seen = 0;
	int token_items = 0;
	int cycles = 0;
	int kind_seen [0:2] = '{0, 0, 0};

	text_tokenizer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit is_single_tok(input logic [7:0] b);
		return b == CH_LBRACE || b == CH_RBRACE || b == CH_LPAREN || b == CH_RPAREN ||
			b == CH_APOS || b == CH_COLON;
	endfunction

	// Zero falls in here too; callers deal with it first.
	function automatic bit is_blank(input logic [7:0] b);
		return b <= CH_SPACE || b[7];
	endfunction

	task automatic emit(input logic [1:0] kind, input logic [7:0] tok, input logic quoted);
		tok_res_t r;
		r.kind = kind;
		r.tok = tok;
		r.quoted = quoted;
		r.last = 1'b0;
		byte_results.push_back(r);
	endtask

	task automatic begin_token(input logic [7:0] b);
		if (b == CH_NUL) begin
			emit(KIND_EOT, 8'h00, 1'b0);
			scan_state = MODE_SKIP;
		end else if (is_blank(b)) begin
			scan_state = MODE_SKIP;
		end else if (b == CH_SLASH) begin
			scan_state = MODE_SLASH;
		end else if (b == CH_QUOTE) begin
			scan_state = MODE_QUOTED;
		end else if (is_single_tok(b)) begin
			emit(KIND_BYTE, b, 1'b0);
			emit(KIND_END, 8'h00, 1'b0);
			scan_state = MODE_SKIP;
		end else begin
			emit(KIND_BYTE, b, 1'b0);
			scan_state = MODE_WORD;
		end
	endtask

	task automatic continue_word(input logic [7:0] b);
		if (b == CH_NUL) begin
			emit(KIND_END, 8'h00, 1'b0);
			emit(KIND_EOT, 8'h00, 1'b0);
			scan_state = MODE_SKIP;
		end else if (is_single_tok(b)) begin
			emit(KIND_END, 8'h00, 1'b0);
			begin_token(b);
		end else if (is_blank(b)) begin
			emit(KIND_END, 8'h00, 1'b0);
			scan_state = MODE_SKIP;
		end else begin
			emit(KIND_BYTE, b, 1'b0);
			scan_state = MODE_WORD;
		end
	endtask

	// Advance the scanner by one accepted byte and queue what it produces.
	task automatic scan_byte(input logic [7:0] b);
		byte_results.delete();
		case (scan_state)
			MODE_SLASH: begin
				if (b == CH_SLASH) begin
					scan_state = MODE_COMMENT;
				end else begin
					emit(KIND_BYTE, CH_SLASH, 1'b0);
					continue_word(b);
				end
			end
			MODE_COMMENT: begin
				if (b == CH_NUL) begin
					emit(KIND_EOT, 8'h00, 1'b0);
					scan_state = MODE_SKIP;
				end else if (b == CH_NL) begin
					scan_state = MODE_SKIP;
				end
			end
			MODE_QUOTED: begin
				if (b == CH_QUOTE) begin
					emit(KIND_END, 8'h00, 1'b1);
					scan_state = MODE_SKIP;
				end else if (b == CH_NUL) begin
					emit(KIND_END, 8'h00, 1'b1);
					emit(KIND_EOT, 8'h00, 1'b0);
					scan_state = MODE_SKIP;
				end else begin
					emit(KIND_BYTE, b, 1'b1);
				end
			end
			MODE_WORD: continue_word(b);
			default: begin_token(b);
		endcase
		if (byte_results.size() > 0)
			byte_results[byte_results.size() - 1].last = 1'b1;
		foreach (byte_results[i])
			expected_tokens.push_back(byte_results[i]);
	endtask

	// Stimulus helpers
	task automatic push_text(input logic [7:0] b, input bit counted);
		text_queue.push_back(b);
		if (counted)
			token_items++;
	endtask

	function automatic logic [7:0] word_char(input bit first);
		logic [7:0] b;
		do
			b = 8'($urandom_range(33, 127));
		while (is_single_tok(b) || (first && (b == CH_QUOTE || b == CH_SLASH)));
		return b;
	endfunction

	function automatic logic [7:0] single_char();
		case ($urandom_range(5))
			0: return CH_LBRACE;
			1: return CH_RBRACE;
			2: return CH_LPAREN;
			3: return CH_RPAREN;
			4: return CH_APOS;
			default: return CH_COLON;
		endcase
	endfunction

	function automatic logic [7:0] blank_char();
		if ($urandom_range(1))
			return 8'($urandom_range(1, 32));
		return 8'($urandom_range(128, 255));
	endfunction

	// Append one token, mostly well formed, followed by an optional blank run.
	task automatic queue_token();
		int pick;
		int len;
		logic [7:0] b;
		pick = $urandom_range(99);
		if (pick < 30) begin
			len = $urandom_range(1, 8);
			for (int i = 0; i < len; i++)
				push_text(word_char(i == 0), 1'b1);
		end else if (pick < 45) begin
			push_text(CH_QUOTE, 1'b1);
			len = $urandom_range(0, 6);
			for (int i = 0; i < len; i++) begin
				do
					b = 8'($urandom_range(1, 255));
				while (b == CH_QUOTE);
				push_text(b, 1'b1);
			end
			push_text(($urandom_range(9) == 0) ? CH_NUL : CH_QUOTE, 1'b1);
		end else if (pick < 60) begin
			push_text(single_char(), 1'b1);
		end else if (pick < 70) begin
			push_text(CH_SLASH, 1'b0);
			push_text(CH_SLASH, 1'b0);
			len = $urandom_range(0, 6);
			for (int i = 0; i < len; i++) begin
				do
					b = 8'($urandom_range(1, 255));
				while (b == CH_NL);
				push_text(b, 1'b0);
			end
			if ($urandom_range(7) == 0)
				push_text(CH_NUL, 1'b1);
			else
				push_text(CH_NL, 1'b0);
		end else if (pick < 78) begin
			// lone slash: the following byte decides what it becomes
			push_text(CH_SLASH, 1'b1);
			case ($urandom_range(3))
				0: push_text(word_char(1'b1), 1'b1);
				1: push_text(single_char(), 1'b1);
				2: push_text(blank_char(), 1'b1);
				default: push_text(CH_NUL, 1'b1);
			endcase
		end else if (pick < 85) begin
			push_text(CH_NUL, 1'b1);
		end else begin
			len = $urandom_range(1, 3);
			for (int i = 0; i < len; i++)
				push_text(8'($urandom_range(0, 255)), 1'b1);
		end
		if ($urandom_range(3) != 0) begin
			len = $urandom_range(1, 2);
			for (int i = 0; i < len; i++)
				push_text(blank_char(), 1'b0);
		end
	endtask

	// Sender side: predict on acceptance, then offer the next byte or idle.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				scan_byte(s_tdata);
				bytes_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (text_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= text_queue.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver side: random stalls and in-order checking of results.
	always @(posedge clk) begin
		tok_res_t want;
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_tokens.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("unexpected result: kind %0d byte %02h quoted %0b last %0b",
							m_tuser[1:0], m_tdata, m_tuser[2], m_tlast);
				end else begin
					want = expected_tokens.pop_front();
					if (m_tuser[1:0] !== want.kind || m_tdata !== want.tok ||
						m_tuser[2] !== want.quoted || m_tlast !== want.last) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display({"mismatch at result %0d: expected kind %0d byte %02h ",
								"quoted %0b last %0b, got kind %0d byte %02h quoted %0b last %0b"},
								results_seen, want.kind, want.tok, want.quoted, want.last,
								m_tuser[1:0], m_tdata, m_tuser[2], m_tlast);
					end else begin
						kind_seen[want.kind]++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_tokens.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int idle_tab [0:3];
		int stall_tab [0:3];
		idle_tab = '{0, 79, 0, 36};
		stall_tab = '{0, 0, 79, 36};
		// extremes, every single-byte token and the scanner's corner cases
		directed_text = '{CH_NUL, 8'h21, CH_NUL,
			CH_SLASH, CH_SLASH, 8'h78, CH_NL, CH_SLASH, CH_SLASH, CH_NUL,
			CH_QUOTE, 8'hff, CH_NUL, CH_QUOTE, CH_QUOTE,
			8'h71, CH_QUOTE, 8'h80, CH_SLASH, CH_RPAREN, 8'h7f, CH_COLON,
			CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_APOS};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = idle_tab[phase];
			recv_stall_pct = stall_tab[phase];
			token_items = 0;
			if (phase == 0)
				foreach (directed_text[i])
					push_text(directed_text[i], 1'b1);
			while (token_items < PHASE_ITEMS)
				queue_token();
			// hold the sender until every result of this phase is out
			do
				@(posedge clk);
			while (text_queue.size() != 0 || s_tvalid || expected_tokens.size() != 0);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		errors += expected_tokens.size();
		$display("run covered %0d text bytes over four handshake pressure phases", bytes_sent);
		$display("checked %0d results: %0d token bytes, %0d token ends, %0d text ends",
			results_seen, kind_seen[0], kind_seen[1], kind_seen[2]);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", errors);
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/tt_pkg.sv
src/tt_front.sv
src/tt_queue.sv
src/tt_back.sv
src/text_tokenizer.sv
bench/testbench.sv
